@@ src/unordered_array_list_defines.svh @@
`ifndef UNORDERED_ARRAY_LIST_DEFINES_SVH
`define UNORDERED_ARRAY_LIST_DEFINES_SVH

// Same-cycle implication, clocked on clk_i, off while rst_ni is low
`define UAL_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("unordered_array_list: check failed");

// Next-cycle implication, clocked on clk_i, off while rst_ni is low
`define UAL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("unordered_array_list: check failed");

`endif

@@ src/ual_pkg.sv @@
package ual_pkg;

  localparam int unsigned VAL_W = 32;
  localparam int unsigned POS_W = 6;
  localparam int unsigned CNT_W = 7;

  // Request codes
  typedef enum logic [1:0] {
    REQ_INSERT  = 2'd0,
    REQ_DELETE  = 2'd1,
    REQ_SEARCH  = 2'd2,
    REQ_DISPLAY = 2'd3
  } req_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  // Input transaction
  typedef struct packed {
    req_e                    req_type;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        position;
  } in_t;

  // Output transaction
  typedef struct packed {
    status_e                 status;
    logic                    found;
    logic signed [VAL_W-1:0] entry_value;
    logic [CNT_W-1:0]        entry_count;
    logic                    last;
  } out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic    start;     // latch request, clear search hit
    logic    idx_zero;  // read pointer to 0
    logic    idx_pos;   // read pointer to position+1, write pointer to position
    logic    rd_en;     // read store at read pointer, advance it
    logic    rd_hold;   // keep read data valid
    logic    cmp_en;    // compare read data against search value
    logic    ins;       // append value, count up
    logic    shift_en;  // write valid read data at write pointer
    logic    cnt_dec;   // count down
    logic    out_load;  // load output register
    logic    out_disp;  // output carries a display entry
    status_e out_status;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    req_e req;
    logic full;
    logic empty;
    logic pos_ok;
    logic idx_end;
    logic rd_vld;
  } dp_stat_t;

endpackage

@@ src/ual_dp.sv @@
module ual_dp #(
  parameter int unsigned DEPTH = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ual_pkg::in_t      in_data_i,
  input  ual_pkg::dp_cmd_t  cmd_i,
  output ual_pkg::dp_stat_t stat_o,
  output ual_pkg::out_t     out_data_o
);
  import ual_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic signed [VAL_W-1:0] mem [DEPTH];

  req_e                    req_q;
  logic signed [VAL_W-1:0] value_q;
  logic [POS_W-1:0]        pos_q;

  logic [CW-1:0]           count_q, count_d;
  logic [CW-1:0]           idx_q, idx_d;
  logic [AW-1:0]           wr_q, wr_d;
  logic                    rd_vld_q, rd_vld_d;
  logic                    hit_q, hit_d;
  logic signed [VAL_W-1:0] rd_data_q;
  out_t                    out_q;

  logic                    mem_we;
  logic [AW-1:0]           mem_wa;
  logic signed [VAL_W-1:0] mem_wd;

  // Request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      req_q   <= in_data_i.req_type;
      value_q <= in_data_i.value;
      pos_q   <= in_data_i.position;
    end
  end

  // Count and pointers
  always_comb begin
    count_d = count_q;
    if (cmd_i.ins) begin
      count_d = count_q + CW'(1);
    end else if (cmd_i.cnt_dec) begin
      count_d = count_q - CW'(1);
    end

    idx_d = idx_q;
    if (cmd_i.idx_zero) begin
      idx_d = '0;
    end else if (cmd_i.idx_pos) begin
      idx_d = CW'(pos_q) + CW'(1);
    end else if (cmd_i.rd_en) begin
      idx_d = idx_q + CW'(1);
    end

    wr_d = wr_q;
    if (cmd_i.idx_pos) begin
      wr_d = AW'(pos_q);
    end else if (cmd_i.shift_en && rd_vld_q) begin
      wr_d = wr_q + AW'(1);
    end

    rd_vld_d = cmd_i.rd_en | (cmd_i.rd_hold & rd_vld_q);
    hit_d    = cmd_i.start ? 1'b0
             : (hit_q | (cmd_i.cmp_en & rd_vld_q & (rd_data_q == value_q)));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      idx_q    <= '0;
      wr_q     <= '0;
      rd_vld_q <= 1'b0;
      hit_q    <= 1'b0;
    end else begin
      count_q  <= count_d;
      idx_q    <= idx_d;
      wr_q     <= wr_d;
      rd_vld_q <= rd_vld_d;
      hit_q    <= hit_d;
    end
  end

  // Store write port: append or shift-down
  always_comb begin
    mem_we = 1'b0;
    mem_wa = wr_q;
    mem_wd = rd_data_q;
    if (cmd_i.ins) begin
      mem_we = 1'b1;
      mem_wa = count_q[AW-1:0];
      mem_wd = value_q;
    end else if (cmd_i.shift_en && rd_vld_q) begin
      mem_we = 1'b1;
    end
  end

  // Store with registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem[idx_q[AW-1:0]];
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.status      <= cmd_i.out_status;
      out_q.found       <= cmd_i.out_disp ? 1'b0 : hit_q;
      out_q.entry_value <= cmd_i.out_disp ? rd_data_q : '0;
      out_q.entry_count <= CNT_W'(count_q);
      out_q.last        <= cmd_i.out_disp ? (idx_q >= count_q) : 1'b1;
    end
  end

  assign out_data_o = out_q;

  // Status to controller
  assign stat_o.req     = req_q;
  assign stat_o.full    = (count_q == CW'(DEPTH));
  assign stat_o.empty   = (count_q == '0);
  assign stat_o.pos_ok  = (CNT_W'(pos_q) < CNT_W'(count_q));
  assign stat_o.idx_end = (idx_q >= count_q);
  assign stat_o.rd_vld  = rd_vld_q;

endmodule

@@ src/ual_ctrl.sv @@
module ual_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  ual_pkg::dp_stat_t stat_i,
  output ual_pkg::dp_cmd_t  cmd_o
);
  import ual_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_DEL,
    S_SRCH,
    S_DISP,
    S_RESULT
  } state_e;

  state_e  state_q;
  logic    out_valid_q;
  status_e res_status_q;
  logic    slot_free;

  // Output register can take a new transaction
  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // Command decode
  always_comb begin
    cmd_o            = '0;
    cmd_o.out_status = ST_OK;
    case (state_q)
      S_IDLE: begin
        cmd_o.start    = in_valid_i;
        cmd_o.idx_zero = in_valid_i;
      end
      S_START: begin
        case (stat_i.req)
          REQ_INSERT: cmd_o.ins     = !stat_i.full;
          REQ_DELETE: cmd_o.idx_pos = stat_i.pos_ok;
          default: ;
        endcase
      end
      S_DEL: begin
        cmd_o.rd_en    = !stat_i.idx_end;
        cmd_o.shift_en = 1'b1;
        cmd_o.cnt_dec  = stat_i.idx_end && !stat_i.rd_vld;
      end
      S_SRCH: begin
        cmd_o.rd_en  = !stat_i.idx_end;
        cmd_o.cmp_en = 1'b1;
      end
      S_DISP: begin
        if (!stat_i.rd_vld) begin
          cmd_o.rd_en = 1'b1;
        end else if (slot_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_disp = 1'b1;
          cmd_o.rd_en    = !stat_i.idx_end;
        end else begin
          cmd_o.rd_hold = 1'b1;
        end
      end
      S_RESULT: begin
        cmd_o.out_load   = slot_free;
        cmd_o.out_status = res_status_q;
      end
      default: ;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      out_valid_q  <= 1'b0;
      res_status_q <= ST_OK;
    end else begin
      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_START;
          end
        end
        S_START: begin
          case (stat_i.req)
            REQ_INSERT: begin
              res_status_q <= stat_i.full ? ST_FULL : ST_OK;
              state_q      <= S_RESULT;
            end
            REQ_DELETE: begin
              if (stat_i.pos_ok) begin
                res_status_q <= ST_OK;
                state_q      <= S_DEL;
              end else begin
                res_status_q <= ST_RANGE;
                state_q      <= S_RESULT;
              end
            end
            REQ_SEARCH: begin
              res_status_q <= ST_OK;
              state_q      <= S_SRCH;
            end
            default: begin
              if (stat_i.empty) begin
                res_status_q <= ST_EMPTY;
                state_q      <= S_RESULT;
              end else begin
                res_status_q <= ST_OK;
                state_q      <= S_DISP;
              end
            end
          endcase
        end
        S_DEL, S_SRCH: begin
          if (stat_i.idx_end && !stat_i.rd_vld) begin
            state_q <= S_RESULT;
          end
        end
        S_DISP: begin
          if (stat_i.rd_vld && slot_free && stat_i.idx_end) begin
            state_q <= S_IDLE;
          end
        end
        S_RESULT: begin
          if (slot_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

@@ src/unordered_array_list.sv @@
// Insert and failed requests go through the start and result states to the output register;
// search reads every entry in turn before its result; delete at position p moves each later
// entry down one position. Results wait in the result state until the output slot is free.
// Display: entries in store order, one entry per cycle while out_ready_i is high.
// One transaction at a time; the next is accepted once the last result is loaded into the
// output register. Reset clears the count and control state, not the store.
`include "unordered_array_list_defines.svh"

module unordered_array_list #(
  parameter int unsigned DEPTH = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ual_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output ual_pkg::out_t out_data_o
);
  import ual_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencer
  ual_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Store, count and output register
  ual_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_data_o (out_data_o)
  );

  // Checks
  `UAL_ASSERT_NOW(a_cnt_bound, out_valid_o, out_data_o.entry_count <= CNT_W'(DEPTH))
  `UAL_ASSERT_NOW(a_empty_res, out_valid_o && (out_data_o.status == ST_EMPTY), (out_data_o.entry_count == '0) && out_data_o.last)
  `UAL_ASSERT_NOW(a_idle_no_rd, in_ready_o, !stat.rd_vld)
  `UAL_ASSERT_NEXT(a_busy_after, in_valid_i && in_ready_o, !in_ready_o)

endmodule

@@ bench/tb_unordered_array_list.sv @@
module tb_unordered_array_list;
  import ual_pkg::*;

  localparam int DEPTH      = 64;
  localparam int N_RANDOM   = 88;
  localparam int MAX_CYCLES = 600000;
  localparam int DRAIN_WAIT = DEPTH + 40;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic out_ready_i = 1'b0;
  in_t  in_data_i   = '0;
  logic in_ready_o;
  logic out_valid_o;
  out_t out_data_o;

  // stimulus waiting for the driver, results waiting for the DUT
  in_t  request_q[$];
  out_t predicted_results[$];

  // list contents as the DUT should hold them
  logic signed [VAL_W-1:0] list_mem [DEPTH];
  int                      list_len = 0;

  // stimulus-side bookkeeping used only to shape requests
  int          gen_len   = 0;
  int          full_hits = 0;
  logic [31:0] seen_vals [64];
  int          seen_n    = 0;

  int          err_cnt    = 0;
  int          cycle_cnt  = 0;
  logic        in_fire    = 1'b0;
  int          burst_left = 1;
  int          idle_left  = 0;
  logic [15:0] ready_pat  = 16'hffff;
  int          pat_age    = 0;

  unordered_array_list #(
    .DEPTH(DEPTH)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  // apply one accepted request to the list and queue the results it causes
  task automatic apply_list_request(input in_t req);
    out_t r;
    logic hit;
    r      = '0;
    r.status = ST_OK;
    r.last = 1'b1;
    hit    = 1'b0;
    case (req.req_type)
      REQ_INSERT: begin
        if (list_len >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          list_mem[list_len] = req.value;
          list_len++;
        end
        r.entry_count = CNT_W'(list_len);
        predicted_results.push_back(r);
      end
      REQ_DELETE: begin
        if (int'(req.position) >= list_len) begin
          r.status = ST_RANGE;
        end else begin
          for (int i = int'(req.position); i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
          list_len--;
        end
        r.entry_count = CNT_W'(list_len);
        predicted_results.push_back(r);
      end
      REQ_SEARCH: begin
        for (int i = 0; i < list_len; i++) if (list_mem[i] == req.value) hit = 1'b1;
        r.found       = hit;
        r.entry_count = CNT_W'(list_len);
        predicted_results.push_back(r);
      end
      default: begin
        if (list_len == 0) begin
          r.status = ST_EMPTY;
          predicted_results.push_back(r);
        end else begin
          for (int i = 0; i < list_len; i++) begin
            r.entry_value = list_mem[i];
            r.entry_count = CNT_W'(list_len);
            r.last        = (i + 1 == list_len);
            predicted_results.push_back(r);
          end
        end
      end
    endcase
  endtask

  // compare one result transaction with the oldest prediction
  task automatic check_result(input out_t got);
    out_t want;
    if (predicted_results.size() == 0) begin
      err_cnt++;
      if (err_cnt <= 10)
        $display("unexpected result: status %0d found %0d value %0d count %0d last %0d",
                 got.status, got.found, got.entry_value, got.entry_count, got.last);
    end else begin
      want = predicted_results.pop_front();
      if (got.status !== want.status || got.found !== want.found ||
          got.entry_value !== want.entry_value || got.entry_count !== want.entry_count ||
          got.last !== want.last) begin
        err_cnt++;
        if (err_cnt <= 10)
          $display("mismatch: exp status %0d found %0d value %0d count %0d last %0d | got status %0d found %0d value %0d count %0d last %0d",
                   want.status, want.found, want.entry_value, want.entry_count, want.last,
                   got.status, got.found, got.entry_value, got.entry_count, got.last);
      end
    end
  endtask

  // queue one request and track the list length it leads to
  task automatic queue_request(input req_e op, input logic [31:0] val, input logic [5:0] pos);
    in_t t;
    t.req_type = op;
    t.value    = val;
    t.position = pos;
    request_q.push_back(t);
    case (op)
      REQ_INSERT: begin
        if (gen_len >= DEPTH) begin
          full_hits++;
        end else begin
          gen_len++;
          seen_vals[seen_n % 64] = val;
          seen_n++;
        end
      end
      REQ_DELETE: if (int'(pos) < gen_len) gen_len--;
      default: ;
    endcase
  endtask

  // one random request; weights in percent for insert, delete, search
  task automatic queue_random(input int w_ins, input int w_del, input int w_srch);
    int          pick;
    logic [31:0] val;
    logic [5:0]  pos;
    pick = $urandom_range(99, 0);
    val  = $urandom;
    pos  = 6'($urandom);
    if (pick < w_ins) begin
      queue_request(REQ_INSERT, val, pos);
    end else if (pick < w_ins + w_del) begin
      // mostly in range, sometimes anywhere
      if (gen_len > 0 && $urandom_range(3, 0) != 0) pos = 6'($urandom_range(gen_len - 1, 0));
      queue_request(REQ_DELETE, val, pos);
    end else if (pick < w_ins + w_del + w_srch) begin
      // half the searches look for a value that was stored at some point
      if (seen_n > 0 && $urandom_range(1, 0) == 1)
        val = seen_vals[$urandom_range((seen_n > 64 ? 64 : seen_n) - 1, 0)];
      queue_request(REQ_SEARCH, val, pos);
    end else begin
      queue_request(REQ_DISPLAY, val, pos);
    end
  endtask

  // stimulus, reset, and end of run
  initial begin
    int n_rand;
    int n_drain;
    // directed: empty list corners
    queue_request(REQ_DISPLAY, $urandom, 6'($urandom));
    queue_request(REQ_DELETE, $urandom, 6'd0);
    queue_request(REQ_SEARCH, 32'h0, 6'($urandom));
    // value extremes
    queue_request(REQ_INSERT, 32'h7fffffff, 6'($urandom));
    queue_request(REQ_INSERT, 32'h80000000, 6'($urandom));
    queue_request(REQ_INSERT, 32'h0, 6'($urandom));
    queue_request(REQ_INSERT, 32'hffffffff, 6'($urandom));
    queue_request(REQ_SEARCH, 32'h80000000, 6'($urandom));
    queue_request(REQ_SEARCH, 32'h7fffffff, 6'($urandom));
    queue_request(REQ_SEARCH, 32'h1, 6'($urandom));
    queue_request(REQ_DISPLAY, $urandom, 6'($urandom));
    // delete out of range, then last and first entries
    queue_request(REQ_DELETE, $urandom, 6'd63);
    queue_request(REQ_DELETE, $urandom, 6'd4);
    queue_request(REQ_DELETE, $urandom, 6'd3);
    queue_request(REQ_DELETE, $urandom, 6'd0);
    queue_request(REQ_DISPLAY, $urandom, 6'($urandom));
    queue_request(REQ_SEARCH, 32'h7fffffff, 6'($urandom));
    queue_request(REQ_DELETE, $urandom, 6'd1);
    queue_request(REQ_DELETE, $urandom, 6'd0);
    queue_request(REQ_DISPLAY, $urandom, 6'($urandom));
    queue_request(REQ_INSERT, 32'h5, 6'($urandom));
    queue_request(REQ_DISPLAY, $urandom, 6'($urandom));

    // fill phase: mostly inserts until the list has refused several
    n_rand = 0;
    while (full_hits < 4 && n_rand < 400) begin
      queue_random(90, 2, 4);
      n_rand++;
    end
    // drain phase: deletes dominate
    n_drain = 0;
    while (n_rand < N_RANDOM || n_drain < 15) begin
      queue_random(20, 45, 15);
      n_rand++;
      n_drain++;
    end

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (request_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (predicted_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (err_cnt == 0 && predicted_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // request driver: bursts with random gaps, valid held until accepted
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_fire) begin
        if (idle_left > 0) begin
          in_valid_i <= 1'b0;
          idle_left  <= idle_left - 1;
        end else if (request_q.size() != 0) begin
          in_valid_i <= 1'b1;
          in_data_i  <= request_q.pop_front();
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(12, 1);
            idle_left  <= ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(6, 1);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result receiver: rotating stall pattern, reshuffled each time pat_age wraps
  always @(negedge clk_i) begin
    if (rst_ni) begin
      out_ready_i <= ready_pat[0];
      if (pat_age == 63) begin
        pat_age   <= 0;
        ready_pat <= ($urandom_range(3, 0) == 0) ? 16'hffff : (16'($urandom) | 16'h1);
      end else begin
        pat_age   <= pat_age + 1;
        ready_pat <= {ready_pat[0], ready_pat[15:1]};
      end
    end
  end

  // monitor: predict on accepted requests, check accepted results
  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_fire <= in_valid_i && in_ready_o;
      if (in_valid_i && in_ready_o) apply_list_request(in_data_i);
      if (out_valid_o && out_ready_i) check_result(out_data_o);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= MAX_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

endmodule
